[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pzfl_pkg.sv]
// ----------------------------------------------------------------------------
// PID feedback loop package
// Widths, constants, codes and shared types of the feedback loop core.
// ----------------------------------------------------------------------------
package pzfl_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int DAC_W      = 12;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int DRV_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Gain scaling, a power of two
    localparam int GAIN_DIVISOR = 256;
    localparam int GAIN_SHIFT   = $clog2(GAIN_DIVISOR);

    // Sample conditioning and limits
    localparam int ADC_OFFSET     = 2048;
    localparam int SCALE_SHIFT    = 4;
    localparam int INTEG_LIMIT    = 1835008;
    localparam int PI_INTEG_MAX   = 32767;
    localparam int PI_INTEG_MIN   = -32768;
    localparam int DRIVE_MAX      = 32767;
    localparam int DRIVE_MIN      = -32768;
    localparam int LOOP_LIMIT_MAX = 1000;

    // Datapath widths of the back end
    localparam int P_W     = ERR_W + GAIN_W;            // err * gain
    localparam int D_W     = DIFF_W + GAIN_W;           // diff * gain_d
    localparam int PQ_W    = P_W - GAIN_SHIFT;          // err * gain / div
    localparam int A_W     = D_W - GAIN_SHIFT - 1;      // diff * gain_d / div / 2
    localparam int INT_W   = 22;                        // integral state
    localparam int DER_W   = 32;                        // derivative state
    localparam int ISUM0_W = INT_W + 1;
    localparam int ZS_W    = ((INT_W > PQ_W) ? INT_W : PQ_W) + 1;
    localparam int PI_W    = INT_W + GAIN_W;            // integ * gain_i
    localparam int SUM_W   = PI_W + 1;
    localparam int Q0_W    = SUM_W - GAIN_SHIFT;
    localparam int Z_W     = ((DER_W > Q0_W) ? DER_W : Q0_W) + 1;

    localparam int BACK_STAGES = 7;

    // Word queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Reset values of the registers
    localparam int SET_POINT_RST  = 1000;
    localparam int GAIN_RST       = 40;
    localparam int LOOP_LIMIT_RST = 30;

    typedef enum logic [1:0] {
        MODE_PID = 2'd0,
        MODE_PI  = 2'd1,
        MODE_P   = 2'd2,
        MODE_OFF = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_PID  = 2'd0,
        OP_PI   = 2'd1,
        OP_P    = 2'd2,
        OP_HOLD = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_SET_POINT  = 3'd1,
        REG_GAIN_P     = 3'd2,
        REG_GAIN_I     = 3'd3,
        REG_GAIN_D     = 3'd4,
        REG_LOOP_LIMIT = 3'd5,
        REG_ENABLE     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [DRV_W-1:0]  set_point;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         loop_limit;
        logic                     enable;
    } cfg_t;

    typedef struct packed {
        op_t                      op;
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic                     done;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // (drive + 32768) >> 4: the offset flips the sign bit
    function automatic logic [DAC_W-1:0] dac_of(input logic signed [DRV_W-1:0] d);
        return {~d[DRV_W-1], d[DRV_W-2:DRV_W-DAC_W]};
    endfunction

endpackage

[sv/pid_z_feedback_loop_core.sv]
// ----------------------------------------------------------------------------
// PID feedback loop core: sample in, saturated drive and DAC code out.
// Result: an accepted sample passes the word queue and the back-end stage registers; output stalls hold it back.
// Throughput: one word per cycle while out_ready does not stall the back end.
// Reset: registers to defaults, loop state and drive to zero, queue emptied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_z_feedback_loop_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [pzfl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pzfl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [pzfl_pkg::ADC_W-1:0]            adc_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pzfl_pkg::DAC_W-1:0]            dac_code,
    output logic                                  dac_write,
    output logic signed [pzfl_pkg::DRV_W-1:0]     drive,
    output logic signed [pzfl_pkg::ERR_W-1:0]     error_value,
    output logic                                  loop_done
);

    pzfl_pkg::cfg_t             cfg_reg;
    pzfl_pkg::cfg_t             cfg_next;
    logic [pzfl_pkg::LIM_W-1:0] lim_wr;
    pzfl_pkg::q_stat_t          q_stat;
    pzfl_pkg::item_t            push_item;
    pzfl_pkg::item_t            pop_item;
    logic                       push;
    logic                       pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        lim_wr   = cfg_data[pzfl_pkg::LIM_W-1:0];
        if (cfg_write)
        begin
            unique case (cfg_index)
                pzfl_pkg::REG_MODE:      cfg_next.mode = pzfl_pkg::mode_t'(cfg_data[1:0]);
                pzfl_pkg::REG_SET_POINT: cfg_next.set_point = $signed(cfg_data);
                pzfl_pkg::REG_GAIN_P:    cfg_next.gain_p = $signed(cfg_data);
                pzfl_pkg::REG_GAIN_I:    cfg_next.gain_i = $signed(cfg_data);
                pzfl_pkg::REG_GAIN_D:    cfg_next.gain_d = $signed(cfg_data);
                pzfl_pkg::REG_LOOP_LIMIT:
                begin
                    // saturate oversized limits
                    if (lim_wr > pzfl_pkg::LIM_W'(pzfl_pkg::LOOP_LIMIT_MAX))
                        cfg_next.loop_limit = pzfl_pkg::LIM_W'(pzfl_pkg::LOOP_LIMIT_MAX);
                    else
                        cfg_next.loop_limit = lim_wr;
                end
                pzfl_pkg::REG_ENABLE:    cfg_next.enable = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= pzfl_pkg::MODE_PID;
            cfg_reg.set_point  <= pzfl_pkg::DRV_W'(pzfl_pkg::SET_POINT_RST);
            cfg_reg.gain_p     <= pzfl_pkg::GAIN_W'(pzfl_pkg::GAIN_RST);
            cfg_reg.gain_i     <= pzfl_pkg::GAIN_W'(pzfl_pkg::GAIN_RST);
            cfg_reg.gain_d     <= pzfl_pkg::GAIN_W'(pzfl_pkg::GAIN_RST);
            cfg_reg.loop_limit <= pzfl_pkg::LIM_W'(pzfl_pkg::LOOP_LIMIT_RST);
            cfg_reg.enable     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pzfl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_sample (adc_sample),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .push       (push),
        .item       (push_item)
    );

    pzfl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (push_item),
        .pop      (pop),
        .item_out (pop_item),
        .stat     (q_stat)
    );

    pzfl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .q_item      (pop_item),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dac_code    (dac_code),
        .dac_write   (dac_write),
        .drive       (drive),
        .error_value (error_value),
        .loop_done   (loop_done)
    );

    `ASSERT_CLK(a_limit_sat, cfg_reg.loop_limit <= pzfl_pkg::LIM_W'(pzfl_pkg::LOOP_LIMIT_MAX), "loop limit above maximum")
    `ASSERT_CLK(a_dac_match, !out_valid || dac_code == pzfl_pkg::dac_of(drive), "dac code does not follow drive")
    `ASSERT_CLK(a_drive_hold, $stable(drive) || dac_write, "drive changed on a hold word")
    `ASSERT_NEXT(a_push_queued, in_valid && in_ready, !q_stat.empty, "accepted word missing from queue")

endmodule

[sv/pzfl_front.sv]
// ----------------------------------------------------------------------------
// PID feedback loop front end
// Accepts samples, forms the error and its difference, classifies the word
// by mode and runs the loop counter.
// ----------------------------------------------------------------------------
module pzfl_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pzfl_pkg::ADC_W-1:0]       adc_sample,
    input  pzfl_pkg::cfg_t                   cfg,
    input  pzfl_pkg::q_stat_t                q_stat,
    output logic                             push,
    output pzfl_pkg::item_t                  item
);

    logic signed [pzfl_pkg::ADC_W:0]      centered;
    logic signed [pzfl_pkg::ERR_W-1:0]    scaled;
    logic signed [pzfl_pkg::ERR_W:0]      err_wide;
    logic signed [pzfl_pkg::ERR_W-1:0]    err;
    logic signed [pzfl_pkg::ERR_W-1:0]    eprev_reg;
    logic [pzfl_pkg::LIM_W-1:0]           count_reg;
    logic [pzfl_pkg::LIM_W-1:0]           count_next;
    logic [pzfl_pkg::LIM_W:0]             count_inc;
    logic                                 done;
    pzfl_pkg::op_t                        op;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        centered = $signed({1'b0, adc_sample})
                 - $signed((pzfl_pkg::ADC_W + 1)'(pzfl_pkg::ADC_OFFSET));
        scaled   = $signed({centered, {pzfl_pkg::SCALE_SHIFT{1'b0}}});
        err_wide = (pzfl_pkg::ERR_W + 1)'(scaled) - (pzfl_pkg::ERR_W + 1)'(cfg.set_point);
        err      = pzfl_pkg::ERR_W'(err_wide);

        count_inc  = {1'b0, count_reg} + (pzfl_pkg::LIM_W + 1)'(1);
        done       = count_inc > {1'b0, cfg.loop_limit};
        count_next = done ? '0 : count_inc[pzfl_pkg::LIM_W-1:0];

        unique case (cfg.mode)
            pzfl_pkg::MODE_PID: op = cfg.enable ? pzfl_pkg::OP_PID : pzfl_pkg::OP_HOLD;
            pzfl_pkg::MODE_PI:  op = cfg.enable ? pzfl_pkg::OP_PI : pzfl_pkg::OP_HOLD;
            pzfl_pkg::MODE_P:   op = pzfl_pkg::OP_P;
            pzfl_pkg::MODE_OFF: op = pzfl_pkg::OP_HOLD;
        endcase

        item.op   = op;
        item.err  = err;
        item.diff = pzfl_pkg::DIFF_W'(err) - pzfl_pkg::DIFF_W'(eprev_reg);
        item.done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            eprev_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
            // PID mode tracks the last error even while disabled
            if (cfg.mode == pzfl_pkg::MODE_PID)
            begin
                eprev_reg <= err;
            end
        end
    end

endmodule

[sv/pzfl_queue.sv]
// ----------------------------------------------------------------------------
// PID feedback loop word queue
// Short FIFO between front and back end.
// ----------------------------------------------------------------------------
module pzfl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pzfl_pkg::item_t    item_in,
    input  logic               pop,
    output pzfl_pkg::item_t    item_out,
    output pzfl_pkg::q_stat_t  stat
);

    pzfl_pkg::item_t                mem_reg [pzfl_pkg::QUEUE_DEPTH];
    logic [pzfl_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [pzfl_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [pzfl_pkg::QUEUE_AW:0]    cnt_reg;
    logic [pzfl_pkg::QUEUE_AW:0]    cnt_next;

    assign item_out   = mem_reg[rd_ptr_reg];
    assign stat.full  = cnt_reg == (pzfl_pkg::QUEUE_AW + 1)'(pzfl_pkg::QUEUE_DEPTH);
    assign stat.empty = cnt_reg == '0;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + (pzfl_pkg::QUEUE_AW + 1)'(1);
            2'b01:   cnt_next = cnt_reg - (pzfl_pkg::QUEUE_AW + 1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + pzfl_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + pzfl_pkg::QUEUE_AW'(1);
            end
        end
    end

endmodule

[sv/pzfl_back.sv]
// ----------------------------------------------------------------------------
// PID feedback loop back end
// Seven-stage datapath: gain products, scaling, integral and derivative
// update, integral product, sums, sum scaling, drive saturation and output register.
// ----------------------------------------------------------------------------
module pzfl_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pzfl_pkg::cfg_t                    cfg,
    input  pzfl_pkg::q_stat_t                 q_stat,
    input  pzfl_pkg::item_t                   q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pzfl_pkg::DAC_W-1:0]        dac_code,
    output logic                              dac_write,
    output logic signed [pzfl_pkg::DRV_W-1:0] drive,
    output logic signed [pzfl_pkg::ERR_W-1:0] error_value,
    output logic                              loop_done
);

    logic [pzfl_pkg::BACK_STAGES-1:0]    vld_reg;
    logic                                adv;

    // Stage 1: gain products
    pzfl_pkg::item_t                     s1_item_reg;
    logic signed [pzfl_pkg::P_W-1:0]     s1_pe_p_reg;
    logic signed [pzfl_pkg::P_W-1:0]     s1_pe_i_reg;
    logic signed [pzfl_pkg::D_W-1:0]     s1_pd_reg;
    logic signed [pzfl_pkg::P_W-1:0]     pe_p_next;
    logic signed [pzfl_pkg::P_W-1:0]     pe_i_next;
    logic signed [pzfl_pkg::D_W-1:0]     pd_next;

    // Stage 2: truncating scale
    pzfl_pkg::item_t                     s2_item_reg;
    logic signed [pzfl_pkg::P_W-1:0]     s2_pe_p_reg;
    logic signed [pzfl_pkg::PQ_W-1:0]    s2_pq_reg;
    logic signed [pzfl_pkg::PQ_W-1:0]    s2_qi_reg;
    logic signed [pzfl_pkg::A_W-1:0]     s2_a_reg;
    logic signed [pzfl_pkg::P_W-1:0]     p_bias;
    logic signed [pzfl_pkg::P_W-1:0]     i_bias;
    logic signed [pzfl_pkg::D_W-1:0]     d_bias;
    logic signed [pzfl_pkg::P_W-1:0]     p_sum;
    logic signed [pzfl_pkg::P_W-1:0]     i_sum;
    logic signed [pzfl_pkg::D_W-1:0]     d_sum;
    logic signed [pzfl_pkg::PQ_W-1:0]    pq_next;
    logic signed [pzfl_pkg::PQ_W-1:0]    qi_next;
    logic signed [pzfl_pkg::A_W-1:0]     a_next;

    // Stage 3: integral and derivative state
    logic signed [pzfl_pkg::INT_W-1:0]   isum_reg;
    logic signed [pzfl_pkg::INT_W-1:0]   isum_next;
    logic signed [pzfl_pkg::DER_W-1:0]   dp_reg;
    logic signed [pzfl_pkg::DER_W-1:0]   dp_next;
    logic signed [pzfl_pkg::ISUM0_W-1:0] c0_sum;
    logic signed [pzfl_pkg::INT_W-1:0]   c0;
    logic signed [pzfl_pkg::ZS_W-1:0]    c1_sum;
    logic signed [pzfl_pkg::INT_W-1:0]   c1;
    logic signed [pzfl_pkg::DER_W:0]     dp_half;
    logic signed [pzfl_pkg::DER_W:0]     dsum;
    logic signed [pzfl_pkg::DER_W-1:0]   dsat;
    pzfl_pkg::item_t                     s3_item_reg;
    logic signed [pzfl_pkg::P_W-1:0]     s3_pe_p_reg;
    logic signed [pzfl_pkg::PQ_W-1:0]    s3_pq_reg;
    logic signed [pzfl_pkg::INT_W-1:0]   s3_integ_reg;
    logic signed [pzfl_pkg::DER_W-1:0]   s3_d_reg;

    // Stage 4: integral product
    pzfl_pkg::item_t                     s4_item_reg;
    logic signed [pzfl_pkg::P_W-1:0]     s4_pe_p_reg;
    logic signed [pzfl_pkg::PQ_W-1:0]    s4_pq_reg;
    logic signed [pzfl_pkg::INT_W-1:0]   s4_integ_reg;
    logic signed [pzfl_pkg::DER_W-1:0]   s4_d_reg;
    logic signed [pzfl_pkg::PI_W-1:0]    s4_pi_reg;
    logic signed [pzfl_pkg::PI_W-1:0]    pi_next;

    // Stage 5: sums
    pzfl_pkg::item_t                     s5_item_reg;
    logic signed [pzfl_pkg::SUM_W-1:0]   s5_sum_reg;
    logic signed [pzfl_pkg::ZS_W-1:0]    s5_zs_reg;
    logic signed [pzfl_pkg::DER_W-1:0]   s5_d_reg;
    logic signed [pzfl_pkg::SUM_W-1:0]   sum_next;
    logic signed [pzfl_pkg::ZS_W-1:0]    zs_next;

    // Stage 6: PID sum scale
    pzfl_pkg::item_t                     s6_item_reg;
    logic signed [pzfl_pkg::Q0_W-1:0]    s6_q0_reg;
    logic signed [pzfl_pkg::ZS_W-1:0]    s6_zs_reg;
    logic signed [pzfl_pkg::DER_W-1:0]   s6_d_reg;
    logic signed [pzfl_pkg::SUM_W-1:0]   s_bias;
    logic signed [pzfl_pkg::SUM_W-1:0]   s_sum;
    logic signed [pzfl_pkg::Q0_W-1:0]    q0_next;

    // Stage 7: saturation and output register
    logic signed [pzfl_pkg::Z_W-1:0]     z;
    logic signed [pzfl_pkg::DRV_W-1:0]   drv_sat;
    logic signed [pzfl_pkg::DRV_W-1:0]   drive_reg;
    logic signed [pzfl_pkg::DRV_W-1:0]   drive_next;
    logic [pzfl_pkg::DAC_W-1:0]          dac_code_reg;
    logic                                dac_write_reg;
    logic signed [pzfl_pkg::ERR_W-1:0]   err_reg;
    logic                                done_reg;

    // Whole pipeline advances together; the queue absorbs the front side
    assign adv       = !vld_reg[pzfl_pkg::BACK_STAGES-1] || out_ready;
    assign q_pop     = adv && !q_stat.empty;
    assign out_valid = vld_reg[pzfl_pkg::BACK_STAGES-1];

    assign dac_code    = dac_code_reg;
    assign dac_write   = dac_write_reg;
    assign drive       = drive_reg;
    assign error_value = err_reg;
    assign loop_done   = done_reg;

    // Stage 1
    always_comb
    begin
        pe_p_next = q_item.err * cfg.gain_p;
        pe_i_next = q_item.err * cfg.gain_i;
        pd_next   = q_item.diff * cfg.gain_d;
    end

    // Stage 2: divide toward zero by biasing negatives before the shift
    always_comb
    begin
        p_bias  = s1_pe_p_reg[pzfl_pkg::P_W-1] ?
                  pzfl_pkg::P_W'(pzfl_pkg::GAIN_DIVISOR - 1) : '0;
        i_bias  = s1_pe_i_reg[pzfl_pkg::P_W-1] ?
                  pzfl_pkg::P_W'(pzfl_pkg::GAIN_DIVISOR - 1) : '0;
        d_bias  = s1_pd_reg[pzfl_pkg::D_W-1] ?
                  pzfl_pkg::D_W'(2 * pzfl_pkg::GAIN_DIVISOR - 1) : '0;
        p_sum   = s1_pe_p_reg + p_bias;
        i_sum   = s1_pe_i_reg + i_bias;
        d_sum   = s1_pd_reg + d_bias;
        pq_next = pzfl_pkg::PQ_W'(p_sum >>> pzfl_pkg::GAIN_SHIFT);
        qi_next = pzfl_pkg::PQ_W'(i_sum >>> pzfl_pkg::GAIN_SHIFT);
        a_next  = pzfl_pkg::A_W'(d_sum >>> (pzfl_pkg::GAIN_SHIFT + 1));
    end

    // Stage 3: integral and derivative state recurrence
    always_comb
    begin
        c0_sum = pzfl_pkg::ISUM0_W'(isum_reg) + pzfl_pkg::ISUM0_W'(s2_item_reg.err);
        priority if (c0_sum > pzfl_pkg::ISUM0_W'(pzfl_pkg::INTEG_LIMIT))
            c0 = pzfl_pkg::INT_W'(pzfl_pkg::INTEG_LIMIT);
        else if (c0_sum < pzfl_pkg::ISUM0_W'(-pzfl_pkg::INTEG_LIMIT))
            c0 = pzfl_pkg::INT_W'(-pzfl_pkg::INTEG_LIMIT);
        else
            c0 = pzfl_pkg::INT_W'(c0_sum);

        c1_sum = pzfl_pkg::ZS_W'(isum_reg) + pzfl_pkg::ZS_W'(s2_qi_reg);
        priority if (c1_sum > pzfl_pkg::ZS_W'(pzfl_pkg::PI_INTEG_MAX))
            c1 = pzfl_pkg::INT_W'(pzfl_pkg::PI_INTEG_MAX);
        else if (c1_sum < pzfl_pkg::ZS_W'(pzfl_pkg::PI_INTEG_MIN))
            c1 = pzfl_pkg::INT_W'(pzfl_pkg::PI_INTEG_MIN);
        else
            c1 = pzfl_pkg::INT_W'(c1_sum);

        // Halve toward zero: add one to negatives before the shift
        dp_half = ((pzfl_pkg::DER_W + 1)'(dp_reg)
                + $signed({{pzfl_pkg::DER_W{1'b0}}, dp_reg[pzfl_pkg::DER_W-1]})) >>> 1;
        dsum    = (pzfl_pkg::DER_W + 1)'(s2_a_reg) + dp_half;
        if (dsum[pzfl_pkg::DER_W] != dsum[pzfl_pkg::DER_W-1])
            dsat = {dsum[pzfl_pkg::DER_W], {(pzfl_pkg::DER_W - 1){~dsum[pzfl_pkg::DER_W]}}};
        else
            dsat = pzfl_pkg::DER_W'(dsum);

        isum_next = isum_reg;
        dp_next   = dp_reg;
        unique case (s2_item_reg.op)
            pzfl_pkg::OP_PID:
            begin
                isum_next = c0;
                dp_next   = dsat;
            end
            pzfl_pkg::OP_PI:   isum_next = c1;
            pzfl_pkg::OP_P:    isum_next = isum_reg;
            pzfl_pkg::OP_HOLD: isum_next = isum_reg;
        endcase
    end

    // Stages 4 to 6
    always_comb
    begin
        pi_next  = s3_integ_reg * cfg.gain_i;
        sum_next = pzfl_pkg::SUM_W'(s4_pe_p_reg) + pzfl_pkg::SUM_W'(s4_pi_reg);
        if (s4_item_reg.op == pzfl_pkg::OP_PI)
            zs_next = pzfl_pkg::ZS_W'(s4_pq_reg) + pzfl_pkg::ZS_W'(s4_integ_reg);
        else
            zs_next = pzfl_pkg::ZS_W'(s4_pq_reg);

        s_bias  = s5_sum_reg[pzfl_pkg::SUM_W-1] ?
                  pzfl_pkg::SUM_W'(pzfl_pkg::GAIN_DIVISOR - 1) : '0;
        s_sum   = s5_sum_reg + s_bias;
        q0_next = pzfl_pkg::Q0_W'(s_sum >>> pzfl_pkg::GAIN_SHIFT);
    end

    // Stage 7
    always_comb
    begin
        if (s6_item_reg.op == pzfl_pkg::OP_PID)
            z = pzfl_pkg::Z_W'(s6_q0_reg) + pzfl_pkg::Z_W'(s6_d_reg);
        else
            z = pzfl_pkg::Z_W'(s6_zs_reg);

        priority if (z > pzfl_pkg::Z_W'(pzfl_pkg::DRIVE_MAX))
            drv_sat = pzfl_pkg::DRV_W'(pzfl_pkg::DRIVE_MAX);
        else if (z < pzfl_pkg::Z_W'(pzfl_pkg::DRIVE_MIN))
            drv_sat = pzfl_pkg::DRV_W'(pzfl_pkg::DRIVE_MIN);
        else
            drv_sat = pzfl_pkg::DRV_W'(z);

        // Hold the last drive when no new value is computed
        drive_next = (s6_item_reg.op == pzfl_pkg::OP_HOLD) ? drive_reg : drv_sat;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg  <= q_item;
            s1_pe_p_reg  <= pe_p_next;
            s1_pe_i_reg  <= pe_i_next;
            s1_pd_reg    <= pd_next;

            s2_item_reg  <= s1_item_reg;
            s2_pe_p_reg  <= s1_pe_p_reg;
            s2_pq_reg    <= pq_next;
            s2_qi_reg    <= qi_next;
            s2_a_reg     <= a_next;

            s3_item_reg  <= s2_item_reg;
            s3_pe_p_reg  <= s2_pe_p_reg;
            s3_pq_reg    <= s2_pq_reg;
            s3_integ_reg <= isum_next;
            s3_d_reg     <= dp_next;

            s4_item_reg  <= s3_item_reg;
            s4_pe_p_reg  <= s3_pe_p_reg;
            s4_pq_reg    <= s3_pq_reg;
            s4_integ_reg <= s3_integ_reg;
            s4_d_reg     <= s3_d_reg;
            s4_pi_reg    <= pi_next;

            s5_item_reg  <= s4_item_reg;
            s5_sum_reg   <= sum_next;
            s5_zs_reg    <= zs_next;
            s5_d_reg     <= s4_d_reg;

            s6_item_reg  <= s5_item_reg;
            s6_q0_reg    <= q0_next;
            s6_zs_reg    <= s5_zs_reg;
            s6_d_reg     <= s5_d_reg;

            dac_code_reg  <= pzfl_pkg::dac_of(drive_next);
            dac_write_reg <= s6_item_reg.op != pzfl_pkg::OP_HOLD;
            err_reg       <= s6_item_reg.err;
            done_reg      <= s6_item_reg.done;
        end
    end

    // Valid bits, loop state and held drive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            isum_reg  <= '0;
            dp_reg    <= '0;
            drive_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[pzfl_pkg::BACK_STAGES-2:0], q_pop};
            if (vld_reg[1])
            begin
                isum_reg <= isum_next;
                dp_reg   <= dp_next;
            end
            if (vld_reg[pzfl_pkg::BACK_STAGES-2])
            begin
                drive_reg <= drive_next;
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the PID feedback loop core
// Drives ADC samples through a valid/ready channel under random idling and
// stalls, and rewrites the loop registers between phases while the core is
// idle. An in-bench model of the control law predicts each output word, and
// every word is compared field by field in arrival order. A short scripted
// run covers the reset state, field extremes, every mode, hold steps,
// a too-large loop limit and a limit lowered below the running count.
// ----------------------------------------------------------------------------
module tb_top;
    import pzfl_pkg::*;

    typedef struct {
        logic [DAC_W-1:0]        dac_code;
        logic                    dac_write;
        logic signed [DRV_W-1:0] drive;
        logic signed [ERR_W-1:0] error_value;
        logic                    loop_done;
    } loop_word_t;

    typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] data;
        logic [ADC_W-1:0]      sample;
        loop_word_t            want;
    } script_row_t;

    localparam longint DERIV_MAX = 64'sh7FFF_FFFF;
    localparam longint DERIV_MIN = -DERIV_MAX - 1;
    localparam int     SEGMENTS  = 12;
    localparam int     SEG_ITEMS = 80;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ADC_W-1:0]      adc_sample = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DAC_W-1:0]      dac_code;
    logic                  dac_write;
    logic signed [DRV_W-1:0] drive;
    logic signed [ERR_W-1:0] error_value;
    logic                  loop_done;

    // Register shadow, at reset values
    mode_t       cfg_mode = MODE_PID;
    longint      sp = SET_POINT_RST;
    longint      kp = GAIN_RST;
    longint      ki = GAIN_RST;
    longint      kd = GAIN_RST;
    int unsigned lim = LOOP_LIMIT_RST;
    bit          en = 1'b1;

    // Loop state
    longint      integ_acc = 0;
    longint      deriv_acc = 0;
    longint      err_last = 0;
    longint      drive_last = 0;
    int unsigned count_now = 0;

    loop_word_t  dac_words_due[$];
    loop_word_t  due_word;
    script_row_t script[$];

    int send_idle_pct = 12;
    int recv_idle_pct = 56;
    int mismatches = 0;
    int words_checked = 0;
    int done_flags = 0;
    int hold_words = 0;
    int samples_sent = 0;
    int settings_written = 0;

    pid_z_feedback_loop_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .adc_sample  (adc_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dac_code    (dac_code),
        .dac_write   (dac_write),
        .drive       (drive),
        .error_value (error_value),
        .loop_done   (loop_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the loop state by one sample and return the word it produces
    function automatic loop_word_t loop_response(input logic [ADC_W-1:0] s);
        longint      err;
        longint      integ;
        longint      d;
        longint      z;
        bit          wrote;
        bit          done;
        int unsigned next_count;
        loop_word_t  w;
        err = (longint'(s) - ADC_OFFSET) * (1 << SCALE_SHIFT) - sp;
        z = 0;
        wrote = 1'b0;
        case (cfg_mode)
            MODE_PID:
            begin
                if (en)
                begin
                    integ = clamp_to(integ_acc + err, -INTEG_LIMIT, INTEG_LIMIT);
                    d = (err - err_last) * kd / GAIN_DIVISOR / 2 + deriv_acc / 2;
                    d = clamp_to(d, DERIV_MIN, DERIV_MAX);
                    integ_acc = integ;
                    z = (err * kp + integ * ki) / GAIN_DIVISOR + d;
                    deriv_acc = d;
                    wrote = 1'b1;
                end
                // error history runs even while disabled
                err_last = err;
            end
            MODE_PI:
            begin
                if (en)
                begin
                    integ = clamp_to(integ_acc + err * ki / GAIN_DIVISOR,
                                     PI_INTEG_MIN, PI_INTEG_MAX);
                    integ_acc = integ;
                    z = err * kp / GAIN_DIVISOR + integ;
                    wrote = 1'b1;
                end
            end
            MODE_P:
            begin
                z = err * kp / GAIN_DIVISOR;
                wrote = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (wrote)
            drive_last = clamp_to(z, DRIVE_MIN, DRIVE_MAX);
        next_count = count_now + 1;
        done = next_count > lim;
        count_now = done ? 0 : (next_count & 'h3ff);
        w.dac_code = DAC_W'((drive_last + 32768) >>> 4);
        w.dac_write = wrote;
        w.drive = DRV_W'(drive_last);
        w.error_value = ERR_W'(err);
        w.loop_done = done;
        return w;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 2047)) - 16'd1024;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t ns: word %0d, %s is %0d, expected %0d", $time, words_checked, field,
                 got, want);
        mismatches++;
    endtask

    task automatic add_write(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
        script_row_t row_v;
        row_v.kind = ROW_WRITE;
        row_v.reg_sel = r;
        row_v.data = d;
        script.push_back(row_v);
    endtask

    task automatic add_sample(input logic [ADC_W-1:0] s);
        script_row_t row_v;
        row_v.kind = ROW_SAMPLE;
        row_v.sample = s;
        script.push_back(row_v);
    endtask

    task automatic add_known(input logic [ADC_W-1:0] s, input int dac, input bit wr,
                             input int drv, input int ev, input bit done);
        script_row_t row_v;
        row_v.kind = ROW_KNOWN;
        row_v.sample = s;
        row_v.want.dac_code = DAC_W'(dac);
        row_v.want.dac_write = wr;
        row_v.want.drive = DRV_W'(drv);
        row_v.want.error_value = ERR_W'(ev);
        row_v.want.loop_done = done;
        script.push_back(row_v);
    endtask

    // Stop sending and hold until every outstanding word is back
    task automatic drain_loop();
        @(negedge clk);
        in_valid <= 1'b0;
        while (dac_words_due.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (r)
            REG_MODE:       cfg_mode = mode_t'(d[1:0]);
            REG_SET_POINT:  sp = longint'($signed(d));
            REG_GAIN_P:     kp = longint'($signed(d));
            REG_GAIN_I:     ki = longint'($signed(d));
            REG_GAIN_D:     kd = longint'($signed(d));
            REG_LOOP_LIMIT: lim = (d[LIM_W-1:0] > LOOP_LIMIT_MAX) ? LOOP_LIMIT_MAX
                                                                  : d[LIM_W-1:0];
            REG_ENABLE:     en = d[0];
            default:
            begin
            end
        endcase
        settings_written++;
    endtask

    task automatic push_sample(input logic [ADC_W-1:0] s, input bit typed,
                               input loop_word_t typed_word);
        loop_word_t w;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            adc_sample <= ADC_W'($urandom_range(0, 4095));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= s;
        do @(posedge clk); while (!in_ready);
        w = loop_response(s);
        dac_words_due.push_back(typed ? typed_word : w);
        samples_sent++;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (dac_words_due.size() == 0)
                report_mismatch("unexpected word, dac_code", dac_code, 0);
            else
            begin
                due_word = dac_words_due.pop_front();
                if (dac_code !== due_word.dac_code)
                    report_mismatch("dac_code", dac_code, due_word.dac_code);
                if (dac_write !== due_word.dac_write)
                    report_mismatch("dac_write", dac_write, due_word.dac_write);
                if (drive !== due_word.drive)
                    report_mismatch("drive", drive, due_word.drive);
                if (error_value !== due_word.error_value)
                    report_mismatch("error_value", error_value, due_word.error_value);
                if (loop_done !== due_word.loop_done)
                    report_mismatch("loop_done", loop_done, due_word.loop_done);
            end
            if (loop_done === 1'b1)
                done_flags++;
            if (dac_write === 1'b0)
                hold_words++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        loop_word_t  no_word;
        int          seg;
        int          k;
        int          level;
        int          run_left;
        int          amp;
        int          v;
        mode_t       mode_pick;
        int unsigned pick;
        logic [LIM_W-1:0] lim_pick;

        run_left = 0;
        level = 2048;
        amp = 0;

        // Reset state, PID at defaults
        add_known(12'd2048, 2023, 1'b1, -390, -1000, 1'b0);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'hAAA);
        add_sample(12'h555);
        // P only at extreme gain and set point, flag on every sample
        add_write(REG_MODE, 16'(MODE_P));
        add_write(REG_GAIN_P, 16'h7FFF);
        add_write(REG_LOOP_LIMIT, 16'h0000);
        add_write(REG_SET_POINT, 16'h8000);
        add_known(12'd4095, 4095, 1'b1, 32767, 65520, 1'b1);
        add_write(REG_SET_POINT, 16'h7FFF);
        add_known(12'd0, 0, 1'b1, -32768, -65535, 1'b1);
        add_write(REG_GAIN_P, 16'h8000);
        add_sample(12'd4095);
        // P only ignores enable
        add_write(REG_ENABLE, 16'h0000);
        add_sample(12'd2048);
        // Disabled PI holds the last drive
        add_write(REG_MODE, 16'(MODE_PI));
        add_known(12'd2048, 4095, 1'b0, 32767, -32767, 1'b1);
        add_write(REG_ENABLE, 16'h0001);
        add_write(REG_GAIN_I, 16'h7FFF);
        add_write(REG_GAIN_P, 16'h0100);
        add_write(REG_SET_POINT, 16'h0000);
        add_sample(12'd4095);
        add_sample(12'd0);
        add_sample(12'd0);
        add_sample(12'd2047);
        // Unused mode computes nothing
        add_write(REG_MODE, 16'(MODE_OFF));
        add_sample(12'd1234);
        // Full PID with extreme derivative swings; limit written too large
        add_write(REG_MODE, 16'(MODE_PID));
        add_write(REG_GAIN_D, 16'h7FFF);
        add_write(REG_GAIN_I, 16'h8000);
        add_write(REG_LOOP_LIMIT, 16'hFFFF);
        add_sample(12'd4095);
        add_sample(12'd0);
        add_sample(12'd4095);
        add_sample(12'd0);
        add_write(REG_ENABLE, 16'h0000);
        add_sample(12'd100);
        add_write(REG_ENABLE, 16'h0001);
        add_sample(12'd3000);
        // Lower the limit below the running count
        add_write(REG_LOOP_LIMIT, 16'h0002);
        add_sample(12'd2049);
        add_sample(12'd2047);
        add_sample(12'd4095);
        add_sample(12'd1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_WRITE:
                begin
                    drain_loop();
                    write_reg(script[i].reg_sel, script[i].data);
                end
                ROW_SAMPLE: push_sample(script[i].sample, 1'b0, no_word);
                default:    push_sample(script[i].sample, 1'b1, script[i].want);
            endcase
        end

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 4) ? 12 : ((seg < 8) ? 56 : 0);
            recv_idle_pct = (seg < 4) ? 56 : ((seg < 8) ? 12 : 0);
            drain_loop();

            pick = $urandom_range(0, 9);
            mode_pick = (pick < 4) ? MODE_PID : ((pick < 7) ? MODE_PI
                                              : ((pick < 9) ? MODE_P : MODE_OFF));
            write_reg(REG_MODE, (16'($urandom) & 16'hFFFC) | 16'(mode_pick));
            write_reg(REG_SET_POINT, pick_word());
            write_reg(REG_GAIN_P, pick_word());
            write_reg(REG_GAIN_I, pick_word());
            write_reg(REG_GAIN_D, pick_word());
            case ($urandom_range(0, 3))
                0:       lim_pick = '0;
                1:       lim_pick = LIM_W'(LOOP_LIMIT_MAX);
                2:       lim_pick = LIM_W'($urandom_range(1, 40));
                default: lim_pick = LIM_W'($urandom_range(0, 1023));
            endcase
            write_reg(REG_LOOP_LIMIT, (16'($urandom) & 16'hFC00) | 16'(lim_pick));
            write_reg(REG_ENABLE, (16'($urandom) & 16'hFFFE) | 16'($urandom_range(0, 6) != 0));

            for (k = 0; k < SEG_ITEMS; k++)
            begin
                // Runs near one level; long runs at a rail wind the integral into its clamp
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 90);
                    case ($urandom_range(0, 3))
                        0:       level = 0;
                        1:       level = 4095;
                        default: level = $urandom_range(0, 4095);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       amp = 0;
                        1:       amp = 8;
                        2:       amp = 200;
                        default: amp = 4096;
                    endcase
                end
                run_left--;
                if (amp >= 4096)
                    v = $urandom_range(0, 4095);
                else
                    v = level + int'($urandom_range(0, 2 * amp)) - amp;
                v = (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
                push_sample(ADC_W'(v), 1'b0, no_word);
            end
        end

        drain_loop();
        repeat (20) @(posedge clk);

        $display("Sent %0d samples across %0d register writes in all four modes.",
                 samples_sent, settings_written);
        $display("Checked %0d words: %0d loop_done flags, %0d hold words, %0d mismatches.",
                 words_checked, done_flags, hold_words, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
